>>> src/fra_pkg.sv
// Shared constants, types and helpers for the room allocator.
package fra_pkg;

  localparam int ROOMS     = 20;
  localparam int ROOM_BASE = 101;
  localparam int IDX_W     = $clog2(ROOMS);
  localparam int CNT_W     = $clog2(ROOMS + 1);
  localparam int CMD_W     = 3;
  localparam int ROOM_W    = 10;
  localparam int TAG_W     = 16;
  localparam int ST_W      = 2;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_OCCUPY     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ASSIGN     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_FREE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST_USED  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_ROOM  = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_ROOM = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

  typedef enum logic [2:0] {
    OP_OCCUPY,
    OP_ASSIGN,
    OP_RELEASE,
    OP_LIST_FREE,
    OP_LIST_USED,
    OP_BAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [ROOM_W-1:0]      room;
    logic [TAG_W-1:0]       tag;
  } op_t;

  typedef struct packed {
    logic [CNT_W-1:0]       free_count;
    logic [ROOMS-1:0]       occupied_mask;
  } bk_stat_t;

  function automatic logic [ROOM_W-1:0] room_of(input logic [IDX_W-1:0] idx);
    room_of = ROOM_W'(ROOM_BASE) + ROOM_W'(idx);
  endfunction

endpackage

>>> src/fra_front.sv
// Front stage: takes input transactions and decodes them into queued operations.
module fra_front
  import fra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [ROOM_W-1:0] room_number,
  input  logic [TAG_W-1:0]  student_id,
  output logic              op_valid,
  input  logic              op_ready,
  output op_t               op
);

  logic              fv;
  op_t               fop;
  op_t               cls;
  logic              in_range;
  logic [ROOM_W:0]   room_ext;

  assign room_ext = {1'b0, room_number};
  assign in_range = (room_ext >= (ROOM_W+1)'(ROOM_BASE)) &&
                    (room_ext <  (ROOM_W+1)'(ROOM_BASE + ROOMS));

  always_comb begin
    cls.in_range = in_range;
    cls.idx      = in_range ? IDX_W'(room_number - ROOM_W'(ROOM_BASE)) : '0;
    cls.room     = room_number;
    cls.tag      = student_id;
    unique case (command)
      CMD_OCCUPY:    cls.kind = OP_OCCUPY;
      CMD_ASSIGN:    cls.kind = OP_ASSIGN;
      CMD_RELEASE:   cls.kind = OP_RELEASE;
      CMD_LIST_FREE: cls.kind = OP_LIST_FREE;
      CMD_LIST_USED: cls.kind = OP_LIST_USED;
      default:       cls.kind = OP_BAD;
    endcase
  end

  assign in_ready = !fv || op_ready;
  assign op_valid = fv;
  assign op       = fop;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv <= 1'b1;
    end else if (op_ready) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fop <= cls;
    end
  end

endmodule

>>> src/fra_queue.sv
// Small operation queue between the front and back stages.
module fra_queue
  import fra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = fill != QCNT_W'(QDEPTH);
  assign pop_valid  = fill != '0;
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        fill <= QCNT_W'(fill + 1'b1);
      end else if (do_pop && !do_push) begin
        fill <= QCNT_W'(fill - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

>>> src/fra_back.sv
// Back stage: free-list sequencer that carries out operations and drives results.
module fra_back
  import fra_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  op_t               op_in,
  output logic              res_valid,
  input  logic              res_ready,
  output logic [ROOM_W-1:0] res_room,
  output logic [TAG_W-1:0]  res_tag,
  output logic [ST_W-1:0]   res_status,
  output logic              res_last,
  output bk_stat_t          stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_UNLINK,
    S_OK_EMIT,
    S_LFREE,
    S_LUSED
  } state_t;

  state_t            state;
  op_t               op;
  logic [ROOMS-1:0]  occupied_mask;
  logic [TAG_W-1:0]  occupant_tag [ROOMS];
  logic [IDX_W-1:0]  free_next [ROOMS];
  logic [IDX_W-1:0]  free_head;
  logic [IDX_W-1:0]  free_tail;
  logic [CNT_W-1:0]  free_count;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  prev;
  logic              have_prev;
  logic [CNT_W-1:0]  n;
  logic              can_emit;
  logic              op_used;
  logic [ROOMS-1:0]  upto;
  logic              free_last;
  logic              used_last;
  logic              res_load;

  assign can_emit  = !res_valid || res_ready;
  assign op_ready  = state == S_IDLE;
  assign op_used   = occupied_mask[op.idx];
  assign upto      = ROOMS'((ROOMS'(2) << n[IDX_W-1:0]) - ROOMS'(1));
  assign free_last = n == CNT_W'(free_count - 1'b1);
  assign used_last = (occupied_mask & ~upto) == '0;
  assign stat.free_count    = free_count;
  assign stat.occupied_mask = occupied_mask;

  // high when the sequencer loads a new result this cycle
  always_comb begin
    res_load = 1'b0;
    unique case (state)
      S_EXEC: begin
        unique case (op.kind)
          OP_OCCUPY:    res_load = can_emit && (!op.in_range || op_used);
          OP_LIST_FREE: res_load = can_emit && (free_count == '0);
          OP_LIST_USED: res_load = can_emit && (occupied_mask == '0);
          default:      res_load = can_emit;
        endcase
      end
      S_OK_EMIT: res_load = can_emit;
      S_LFREE:   res_load = can_emit;
      S_LUSED:   res_load = can_emit && occupied_mask[n[IDX_W-1:0]];
      default:   res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      occupied_mask <= '0;
      free_head     <= '0;
      free_tail     <= IDX_W'(ROOMS - 1);
      free_count    <= CNT_W'(ROOMS);
      for (int i = 0; i < ROOMS; i++) begin
        free_next[i] <= (i + 1 < ROOMS) ? IDX_W'(i + 1) : '0;
      end
    end else begin
      if (res_valid && res_ready && !res_load) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            op    <= op_in;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op.kind)
            OP_OCCUPY: begin
              if (!op.in_range || op_used) begin
                if (can_emit) begin
                  res_valid  <= 1'b1;
                  res_room   <= op.room;
                  res_tag    <= '0;
                  res_status <= ST_BAD_ROOM;
                  res_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end else begin
                cur       <= free_head;
                prev      <= '0;
                have_prev <= 1'b0;
                state     <= S_UNLINK;
              end
            end
            OP_ASSIGN: begin
              if (can_emit) begin
                res_valid <= 1'b1;
                res_last  <= 1'b1;
                state     <= S_IDLE;
                if (free_count == '0) begin
                  res_room   <= '0;
                  res_tag    <= '0;
                  res_status <= ST_NO_ROOM;
                end else begin
                  free_head                <= free_next[free_head];
                  free_count               <= CNT_W'(free_count - 1'b1);
                  occupied_mask[free_head] <= 1'b1;
                  occupant_tag[free_head]  <= op.tag;
                  res_room                 <= room_of(free_head);
                  res_tag                  <= op.tag;
                  res_status               <= ST_OK;
                end
              end
            end
            OP_RELEASE: begin
              if (can_emit) begin
                res_valid <= 1'b1;
                res_room  <= op.room;
                res_tag   <= '0;
                res_last  <= 1'b1;
                state     <= S_IDLE;
                if (!op.in_range || !op_used) begin
                  res_status <= ST_BAD_ROOM;
                end else begin
                  res_status            <= ST_OK;
                  occupied_mask[op.idx] <= 1'b0;
                  // append at the tail; an empty list restarts at the head
                  if (free_count == '0) begin
                    free_head <= op.idx;
                  end else begin
                    free_next[free_tail] <= op.idx;
                  end
                  free_tail  <= op.idx;
                  free_count <= CNT_W'(free_count + 1'b1);
                end
              end
            end
            OP_LIST_FREE: begin
              if (free_count == '0) begin
                if (can_emit) begin
                  res_valid  <= 1'b1;
                  res_room   <= '0;
                  res_tag    <= '0;
                  res_status <= ST_EMPTY;
                  res_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end else begin
                cur   <= free_head;
                n     <= '0;
                state <= S_LFREE;
              end
            end
            OP_LIST_USED: begin
              if (occupied_mask == '0) begin
                if (can_emit) begin
                  res_valid  <= 1'b1;
                  res_room   <= '0;
                  res_tag    <= '0;
                  res_status <= ST_EMPTY;
                  res_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end else begin
                n     <= '0;
                state <= S_LUSED;
              end
            end
            default: begin
              if (can_emit) begin
                res_valid  <= 1'b1;
                res_room   <= '0;
                res_tag    <= '0;
                res_status <= ST_BAD_ROOM;
                res_last   <= 1'b1;
                state      <= S_IDLE;
              end
            end
          endcase
        end
        S_UNLINK: begin
          // walk the free list one link per cycle until the room is found
          if (cur == op.idx) begin
            if (!have_prev) begin
              free_head <= free_next[cur];
            end else begin
              free_next[prev] <= free_next[cur];
            end
            if (cur == free_tail) begin
              free_tail <= prev;
            end
            free_count            <= CNT_W'(free_count - 1'b1);
            occupied_mask[op.idx] <= 1'b1;
            occupant_tag[op.idx]  <= op.tag;
            state                 <= S_OK_EMIT;
          end else begin
            prev      <= cur;
            have_prev <= 1'b1;
            cur       <= free_next[cur];
          end
        end
        S_OK_EMIT: begin
          if (can_emit) begin
            res_valid  <= 1'b1;
            res_room   <= op.room;
            res_tag    <= '0;
            res_status <= ST_OK;
            res_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_LFREE: begin
          if (can_emit) begin
            res_valid  <= 1'b1;
            res_room   <= room_of(cur);
            res_tag    <= '0;
            res_status <= ST_OK;
            res_last   <= free_last;
            cur        <= free_next[cur];
            n          <= CNT_W'(n + 1'b1);
            if (free_last) begin
              state <= S_IDLE;
            end
          end
        end
        S_LUSED: begin
          // skip free rooms without a result
          if (!occupied_mask[n[IDX_W-1:0]]) begin
            n <= CNT_W'(n + 1'b1);
          end else if (can_emit) begin
            res_valid  <= 1'b1;
            res_room   <= room_of(n[IDX_W-1:0]);
            res_tag    <= occupant_tag[n[IDX_W-1:0]];
            res_status <= ST_OK;
            res_last   <= used_last;
            n          <= CNT_W'(n + 1'b1);
            if (used_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/fifo_room_allocator.sv
// Room allocator top level: front decode, operation queue and free-list back end.
// A successful occupy first walks the free list link by link up to the room, which can have
// up to ROOMS-1 links ahead of it. List free gives one result per cycle while the receiver is
// ready; list used also skips free rooms without a result. The back end takes a new command
// only after the last result of the previous one; the front stage and queue buffer commands.
// Synchronous active-high reset: all rooms free, free list in ascending order.
module fifo_room_allocator
  import fra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // command[2:0], room_number[12:3], student_id[28:13]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // room_number_res[9:0], student_id_res[25:10]
  output logic [1:0]  m_tuser,   // status[1:0]
  output logic        m_tlast
);

  logic              fq_valid;
  logic              fq_ready;
  op_t               fq_op;
  logic              qb_valid;
  logic              qb_ready;
  op_t               qb_op;
  logic [ROOM_W-1:0] res_room;
  logic [TAG_W-1:0]  res_tag;
  bk_stat_t          stat;

  fra_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (s_tdata[2:0]),
    .room_number (s_tdata[12:3]),
    .student_id  (s_tdata[28:13]),
    .op_valid    (fq_valid),
    .op_ready    (fq_ready),
    .op          (fq_op)
  );

  fra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_op    (fq_op),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_op     (qb_op)
  );

  fra_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (qb_valid),
    .op_ready   (qb_ready),
    .op_in      (qb_op),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_room   (res_room),
    .res_tag    (res_tag),
    .res_status (m_tuser),
    .res_last   (m_tlast),
    .stat       (stat)
  );

  assign m_tdata = {6'd0, res_tag, res_room};

  // every room is either on the free list or occupied, never both
  a_room_balance: assert property (@(posedge clk) disable iff (rst)
    (32'(stat.free_count) + 32'($countones(stat.occupied_mask))) == ROOMS)
    else $error("free count and occupied rooms do not add up");

  // a failed or empty command gives exactly one result
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tlast)
    else $error("failure result not marked last");

  // empty listing and no-room results carry no room
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_EMPTY || m_tuser == ST_NO_ROOM)) |-> (m_tdata == '0))
    else $error("empty or no-room result carries data");

  // an empty free list means every room is occupied
  a_full_mask: assert property (@(posedge clk) disable iff (rst)
    (stat.free_count == '0) |-> (stat.occupied_mask == {ROOMS{1'b1}}))
    else $error("free list empty but not all rooms occupied");

endmodule

>>> test/fra_result_checker.sv
// Result checker for the room allocator: predicts every transaction and compares the output stream.
`timescale 1ns / 100ps
module fra_result_checker
  import fra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // command[2:0], room_number[12:3], student_id[28:13]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // room_number_res[9:0], student_id_res[25:10]
  input  logic [1:0]  m_tuser,   // status[1:0]
  input  logic        m_tlast,
  output int          fail_count,
  output int          expected_left
);

  typedef struct packed {
    logic [ROOM_W-1:0] room;
    logic [TAG_W-1:0]  tag;
    logic [ST_W-1:0]   status;
    logic              last;
  } room_result_t;

  room_result_t      room_results_q[$];

  // Shadow copy of the allocator state
  logic [ROOMS-1:0]  used_mask;
  logic [TAG_W-1:0]  used_tag[ROOMS];
  int                fl_next[ROOMS];
  int                fl_head;
  int                fl_tail;
  int                fl_count;

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  task automatic flag_mismatch(input string what);
    if (fail_count < 100) $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic reset_rooms();
    used_mask = '0;
    for (int i = 0; i < ROOMS; i++) begin
      used_tag[i] = '0;
      fl_next[i]  = (i + 1 < ROOMS) ? i + 1 : 0;
    end
    fl_head  = 0;
    fl_tail  = ROOMS - 1;
    fl_count = ROOMS;
    room_results_q.delete();
  endtask

  task automatic push_result(input int room, input logic [TAG_W-1:0] tag,
                             input logic [ST_W-1:0] st, input logic last);
    room_result_t r;
    r.room   = ROOM_W'(room);
    r.tag    = tag;
    r.status = st;
    r.last   = last;
    room_results_q.insert(room_results_q.size(), r);
  endtask

  // Remove a free room from wherever it sits in the free list.
  task automatic unlink_room(input int idx);
    int cur;
    int prev;
    bit have_prev;
    bit done;
    cur       = fl_head % ROOMS;
    prev      = 0;
    have_prev = 0;
    done      = 0;
    for (int n = 0; n < fl_count && n < ROOMS && !done; n++) begin
      if (cur == idx) begin
        if (!have_prev) fl_head = fl_next[cur] % ROOMS;
        else fl_next[prev] = fl_next[cur] % ROOMS;
        if (cur == fl_tail % ROOMS) fl_tail = prev;
        fl_count--;
        done = 1;
      end else begin
        prev      = cur;
        have_prev = 1;
        cur       = fl_next[cur] % ROOMS;
      end
    end
  endtask

  task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [ROOM_W-1:0] rn,
                               input logic [TAG_W-1:0] tg);
    bit in_range;
    int idx;
    int cur;
    int last_used;
    in_range = (rn >= ROOM_BASE) && (rn < ROOM_BASE + ROOMS);
    idx      = in_range ? int'(rn) - ROOM_BASE : 0;
    case (cmd)
      CMD_OCCUPY: begin
        if (!in_range || used_mask[idx]) begin
          push_result(int'(rn), '0, ST_BAD_ROOM, 1'b1);
        end else begin
          unlink_room(idx);
          used_mask[idx] = 1'b1;
          used_tag[idx]  = tg;
          push_result(int'(rn), '0, ST_OK, 1'b1);
        end
      end
      CMD_ASSIGN: begin
        if (fl_count == 0) begin
          push_result(0, '0, ST_NO_ROOM, 1'b1);
        end else begin
          cur            = fl_head % ROOMS;
          fl_head        = fl_next[cur] % ROOMS;
          fl_count--;
          used_mask[cur] = 1'b1;
          used_tag[cur]  = tg;
          push_result(ROOM_BASE + cur, tg, ST_OK, 1'b1);
        end
      end
      CMD_RELEASE: begin
        if (!in_range || !used_mask[idx]) begin
          push_result(int'(rn), '0, ST_BAD_ROOM, 1'b1);
        end else begin
          used_mask[idx] = 1'b0;
          if (fl_count == 0) fl_head = idx;
          else fl_next[fl_tail % ROOMS] = idx;
          fl_tail = idx;
          fl_count++;
          push_result(int'(rn), '0, ST_OK, 1'b1);
        end
      end
      CMD_LIST_FREE: begin
        cur = fl_head % ROOMS;
        for (int n = 0; n < fl_count && n < ROOMS; n++) begin
          push_result(ROOM_BASE + cur, '0, ST_OK, n == fl_count - 1 || n == ROOMS - 1);
          cur = fl_next[cur] % ROOMS;
        end
        if (fl_count == 0) push_result(0, '0, ST_EMPTY, 1'b1);
      end
      CMD_LIST_USED: begin
        last_used = -1;
        for (int i = 0; i < ROOMS; i++)
          if (used_mask[i]) last_used = i;
        for (int i = 0; i < ROOMS; i++)
          if (used_mask[i]) push_result(ROOM_BASE + i, used_tag[i], ST_OK, i == last_used);
        if (last_used < 0) push_result(0, '0, ST_EMPTY, 1'b1);
      end
      default: begin
        push_result(0, '0, ST_BAD_ROOM, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    room_result_t want;
    if (rst) begin
      reset_rooms();
    end else begin
      if (s_tvalid && s_tready)
        apply_command(s_tdata[2:0], s_tdata[12:3], s_tdata[28:13]);
      if (m_tvalid && m_tready) begin
        if (room_results_q.size() == 0) begin
          flag_mismatch($sformatf("result with nothing expected: room %0d tag %h status %0d",
                                  m_tdata[9:0], m_tdata[25:10], m_tuser));
        end else begin
          want = room_results_q[0];
          room_results_q.delete(0);
          if (m_tdata[9:0] != want.room)
            flag_mismatch($sformatf("room %0d, expected %0d", m_tdata[9:0], want.room));
          if (m_tdata[25:10] != want.tag)
            flag_mismatch($sformatf("tag %h, expected %h", m_tdata[25:10], want.tag));
          if (m_tuser != want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
          if (m_tlast != want.last)
            flag_mismatch($sformatf("last %0b, expected %0b", m_tlast, want.last));
        end
      end
    end
    expected_left = room_results_q.size();
  end

endmodule

>>> test/tb_fifo_room_allocator.sv
// Testbench top for the room allocator: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb_fifo_room_allocator;
  import fra_pkg::*;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_SPREAD, MIX_LISTS} cmd_mix_t;

  localparam int LONG_HOLD = 400;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [31:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int          fail_count;
  int          expected_left;
  bit          hold_req    = 1'b0;
  bit          steady_send = 1'b0;
  int          burst_left  = 0;

  fifo_room_allocator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  fra_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Offer one command and hold it until the transaction completes.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [ROOM_W-1:0] rn,
                          input logic [TAG_W-1:0] tg);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, tg, rn, cmd};
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap        = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
  endtask

  function automatic logic [ROOM_W-1:0] pick_room();
    int w;
    w = $urandom_range(0, 99);
    if (w < 85) return ROOM_W'(ROOM_BASE + $urandom_range(0, ROOMS - 1));
    if (w < 95) return ROOM_W'($urandom_range(0, (1 << ROOM_W) - 1));
    case ($urandom_range(0, 3))
      0: return ROOM_W'(ROOM_BASE - 1);
      1: return ROOM_W'(ROOM_BASE + ROOMS);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pick_tag();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
    endcase
  endfunction

  task automatic send_random(input cmd_mix_t mix);
    int w;
    logic [CMD_W-1:0] cmd;
    w = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        cmd = (w < 50) ? CMD_ASSIGN : (w < 75) ? CMD_OCCUPY : (w < 85) ? CMD_RELEASE :
              (w < 90) ? CMD_LIST_FREE : (w < 95) ? CMD_LIST_USED : CMD_W'(CMD_LIST_USED + 1);
      MIX_DRAIN:
        cmd = (w < 55) ? CMD_RELEASE : (w < 65) ? CMD_ASSIGN : (w < 75) ? CMD_OCCUPY :
              (w < 85) ? CMD_LIST_FREE : (w < 95) ? CMD_LIST_USED : CMD_W'(CMD_LIST_USED + 1);
      MIX_LISTS:
        cmd = (w < 40) ? CMD_LIST_FREE : (w < 80) ? CMD_LIST_USED : (w < 88) ? CMD_ASSIGN :
              (w < 96) ? CMD_RELEASE : CMD_OCCUPY;
      default:
        cmd = (w < 22) ? CMD_OCCUPY : (w < 44) ? CMD_ASSIGN : (w < 66) ? CMD_RELEASE :
              (w < 78) ? CMD_LIST_FREE : (w < 90) ? CMD_LIST_USED : CMD_W'(CMD_LIST_USED + 1);
    endcase
    // Spread undefined codes over every unused encoding
    if (cmd > CMD_LIST_USED) cmd = CMD_W'($urandom_range(CMD_LIST_USED + 1, {CMD_W{1'b1}}));
    send_cmd(cmd, pick_room(), pick_tag());
  endtask

  // Receiver: random ready patterns, plus one long hold-off on request.
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    int pct;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    pct       = 100;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
          case (mode)
            0: pct = 100;
            1: pct = 50;
            2: pct = 85;
            default: pct = 20;
          endcase
        end
        mode_left--;
        m_tready <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  initial begin
    cmd_mix_t mix;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: full and empty listings, list head, tail and middle, range edges
    send_cmd(CMD_LIST_FREE, '0, '0);
    send_cmd(CMD_LIST_USED, '0, '0);
    send_cmd(CMD_OCCUPY, ROOM_W'(ROOM_BASE), 16'h1234);
    send_cmd(CMD_OCCUPY, ROOM_W'(ROOM_BASE + ROOMS - 1), '1);
    send_cmd(CMD_OCCUPY, ROOM_W'(ROOM_BASE + 9), 16'h0001);
    send_cmd(CMD_OCCUPY, ROOM_W'(ROOM_BASE + 9), 16'h0002);
    send_cmd(CMD_OCCUPY, ROOM_W'(ROOM_BASE - 1), 16'h5555);
    send_cmd(CMD_RELEASE, ROOM_W'(ROOM_BASE + ROOMS), '0);
    send_cmd(CMD_OCCUPY, '1, '1);
    send_cmd(CMD_RELEASE, '0, '0);
    send_cmd(CMD_RELEASE, ROOM_W'(ROOM_BASE + 5), 16'hAAAA);
    send_cmd(CMD_ASSIGN, '0, '1);
    send_cmd(CMD_ASSIGN, '1, '0);
    send_cmd(CMD_RELEASE, ROOM_W'(ROOM_BASE + 9), '0);
    send_cmd(CMD_RELEASE, ROOM_W'(ROOM_BASE + ROOMS - 1), '0);
    send_cmd(CMD_LIST_FREE, '1, '1);
    send_cmd(CMD_LIST_USED, '1, '1);
    for (int c = CMD_LIST_USED + 1; c <= {CMD_W{1'b1}}; c++)
      send_cmd(CMD_W'(c), pick_room(), pick_tag());
    drain_results();

    // Random: blocks of biased mixes so the pool runs full and empty repeatedly
    for (int blk = 0; blk < 8; blk++) begin
      steady_send = ($urandom_range(0, 3) == 0);
      mix         = cmd_mix_t'($urandom_range(0, 3));
      if (blk == 0 || blk == 5) mix = MIX_FILL;
      if (blk == 1 || blk == 6) mix = MIX_DRAIN;
      if (blk == 3) begin
        // Long receiver hold-off while listings pile up behind it
        mix         = MIX_LISTS;
        steady_send = 1'b1;
        hold_req    = 1'b1;
      end
      if (blk == 4) drain_results();
      for (int n = 0; n < 40; n++) send_random(mix);
    end

    drain_results();
    repeat (ROOMS * 3) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> fifo_room_allocator.f
src/fra_pkg.sv
src/fra_front.sv
src/fra_queue.sv
src/fra_back.sv
src/fifo_room_allocator.sv
test/fra_result_checker.sv
test/tb_fifo_room_allocator.sv
